// ===== design/rmqt_pkg.sv =====
// Package for the range minimum query table.
// Shared widths, command and status codes, controller/datapath structs.
// No dependencies.
package rmqt_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int DATA_W       = 32;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_BUILD  = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RANGE = 2'd1,
    ST_NOT_BUILT = 2'd2
  } status_t;

  typedef struct packed {
    logic scan;
    logic emit;
  } dp_ctrl_t;

  typedef struct packed {
    logic query_go;
    logic query_ok;
    logic issue_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/rmqt_ctrl.sv =====
// Controller for the range minimum query table.
// Sequences the element scan and result beat; depends on rmqt_pkg.
module rmqt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  rmqt_pkg::dp_stat_t stat,
  output rmqt_pkg::dp_ctrl_t ctrl,
  output logic              in_ready
);
  import rmqt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_WAIT = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (stat.query_go) begin
          state_nxt = stat.query_ok ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        ctrl.scan = 1'b1;
        if (stat.issue_last) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctrl.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== design/rmqt_dp.sv =====
// Datapath for the range minimum query table.
// Element store, count, built mark, scan and result register; uses rmqt_pkg.
module rmqt_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_fire,
  input  logic [1:0]                        in_command,
  input  logic signed [rmqt_pkg::DATA_W-1:0] in_value,
  input  logic [rmqt_pkg::ADDR_W-1:0]       in_left_index,
  input  logic [rmqt_pkg::ADDR_W-1:0]       in_right_index,
  input  rmqt_pkg::dp_ctrl_t                ctrl,
  output rmqt_pkg::dp_stat_t                stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rmqt_pkg::DATA_W-1:0] out_min_value,
  output logic [1:0]                        out_status
);
  import rmqt_pkg::*;

  logic signed [DATA_W-1:0] mem [MAX_ELEMENTS];

  logic [CNT_W-1:0]         count_r;
  logic                     built_r;
  logic [ADDR_W-1:0]        idx_r;
  logic [ADDR_W-1:0]        right_r;
  logic signed [DATA_W-1:0] rd_r;
  logic                     rdv_r;
  logic signed [DATA_W-1:0] min_r;
  status_t                  code_r, code_nxt;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_min_r;
  status_t                  out_status_r;
  cmd_t                     cmd;

  assign cmd = cmd_t'(in_command);

  always_comb begin
    if (!built_r) begin
      code_nxt = ST_NOT_BUILT;
    end else if (in_left_index > in_right_index ||
                 {1'b0, in_right_index} >= count_r) begin
      code_nxt = ST_BAD_RANGE;
    end else begin
      code_nxt = ST_OK;
    end
  end

  assign stat.query_go   = in_fire && cmd == CMD_QUERY;
  assign stat.query_ok   = code_nxt == ST_OK;
  assign stat.issue_last = idx_r == right_r;
  assign stat.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (in_fire && cmd == CMD_APPEND && count_r < CNT_W'(MAX_ELEMENTS)) begin
      mem[count_r[ADDR_W-1:0]] <= in_value;
    end
    rd_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      built_r     <= 1'b0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rdv_r <= ctrl.scan;
      if (in_fire) begin
        unique case (cmd)
          CMD_CLEAR: begin
            count_r <= '0;
            built_r <= 1'b0;
          end
          CMD_APPEND: begin
            if (count_r < CNT_W'(MAX_ELEMENTS)) begin
              count_r <= count_r + 1'b1;
              built_r <= 1'b0;
            end
          end
          CMD_BUILD: built_r <= 1'b1;
          CMD_QUERY: ;
          default: ;
        endcase
      end
      if (ctrl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat.query_go) begin
      idx_r   <= in_left_index;
      right_r <= in_right_index;
      code_r  <= code_nxt;
      min_r   <= {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      if (ctrl.scan) begin
        idx_r <= idx_r + 1'b1;
      end
      if (rdv_r && rd_r < min_r) begin
        min_r <= rd_r;
      end
    end
    if (ctrl.emit) begin
      out_min_r    <= (code_r == ST_OK) ? min_r : '0;
      out_status_r <= code_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_min_value = out_min_r;
  assign out_status    = out_status_r;

endmodule

// ===== design/range_minimum_query_table.sv =====
// Range minimum query table, top level: controller plus datapath.
// Clear, append and build are taken while idle; a query scans its range, one
// element per cycle from the single-read element store, and an error query
// skips the scan. A new command waits until the last result is registered.
// Synchronous active-low reset empties the store and clears the built mark.
module range_minimum_query_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_command,
  input  logic signed [rmqt_pkg::DATA_W-1:0] in_value,
  input  logic [rmqt_pkg::ADDR_W-1:0]       in_left_index,
  input  logic [rmqt_pkg::ADDR_W-1:0]       in_right_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rmqt_pkg::DATA_W-1:0] out_min_value,
  output logic [1:0]                        out_status
);
  import rmqt_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;
  logic     in_fire;

  assign in_fire = in_valid && in_ready;

  rmqt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_ready (in_ready)
  );

  rmqt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .in_command     (in_command),
    .in_value       (in_value),
    .in_left_index  (in_left_index),
    .in_right_index (in_right_index),
    .ctrl           (ctrl),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_min_value  (out_min_value),
    .out_status     (out_status)
  );

endmodule

// ===== tb/sv/range_minimum_query_table_tb.sv =====
// Self-checking testbench for range_minimum_query_table.
// Drives clear/append/build/query beats against an in-bench minimum predictor.
// Depends on rmqt_pkg and the range_minimum_query_table RTL.
module range_minimum_query_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmqt_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_TOTAL = 450;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    status_t status;
  } min_result_t;

  typedef struct {
    cmd_t cmd;
    logic signed [DATA_W-1:0] value;
    logic [ADDR_W-1:0] left;
    logic [ADDR_W-1:0] right;
    bit typed;
    logic signed [DATA_W-1:0] want_value;
    status_t want_status;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_command;
  logic signed [DATA_W-1:0] in_value;
  logic [ADDR_W-1:0] in_left_index;
  logic [ADDR_W-1:0] in_right_index;
  logic out_valid;
  logic out_ready;
  logic signed [DATA_W-1:0] out_min_value;
  logic [1:0] out_status;

  logic signed [DATA_W-1:0] shadow_store [MAX_ELEMENTS];
  int shadow_count;
  bit shadow_built;
  min_result_t pending_mins [$];
  int mismatches;
  int idle_cycles;
  int burst_left;
  int sent;
  bit hold_go;
  bit stim_done;

  range_minimum_query_table dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic min_result_t predict_min(int l, int r);
    min_result_t res;
    res.value = '0;
    if (!shadow_built) res.status = ST_NOT_BUILT;
    else if (l > r || r >= shadow_count) res.status = ST_BAD_RANGE;
    else begin
      res.status = ST_OK;
      res.value = shadow_store[l];
      for (int i = l + 1; i <= r; i++)
        if (shadow_store[i] < res.value) res.value = shadow_store[i];
    end
    return res;
  endfunction

  task automatic apply_beat(stim_row_t row);
    min_result_t res;
    case (row.cmd)
      CMD_CLEAR: begin
        shadow_count = 0;
        shadow_built = 0;
      end
      CMD_APPEND: begin
        if (shadow_count < MAX_ELEMENTS) begin
          shadow_store[shadow_count] = row.value;
          shadow_count++;
          shadow_built = 0;
        end
      end
      CMD_BUILD: shadow_built = 1;
      default: begin
        res = predict_min(int'(row.left), int'(row.right));
        if (row.typed) begin
          res.value = row.want_value;
          res.status = row.want_status;
        end
        pending_mins.push_back(res);
      end
    endcase
  endtask

  task automatic send_beat(stim_row_t row);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_command <= row.cmd;
    in_value <= row.value;
    in_left_index <= row.left;
    in_right_index <= row.right;
    do @(posedge clk); while (!in_ready);
    apply_beat(row);
    sent++;
    @(negedge clk);
  endtask

  function automatic stim_row_t mk(cmd_t c, logic signed [DATA_W-1:0] v = '0,
                                   int l = 0, int r = 0);
    stim_row_t row;
    row.cmd = c;
    row.value = v;
    row.left = ADDR_W'(l);
    row.right = ADDR_W'(r);
    row.typed = 0;
    row.want_value = '0;
    row.want_status = ST_OK;
    return row;
  endfunction

  function automatic stim_row_t mkq(int l, int r, logic signed [DATA_W-1:0] v,
                                    status_t s);
    stim_row_t row;
    row = mk(CMD_QUERY, $urandom(), l, r);
    row.typed = 1;
    row.want_value = v;
    row.want_status = s;
    return row;
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value(bit narrow);
    if (narrow) return $signed($urandom_range(0, 6)) - 3;
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      default: return $urandom();
    endcase
  endfunction

  function automatic stim_row_t rand_query();
    int l, r;
    if (shadow_count > 0 && $urandom_range(0, 99) < 85) begin
      l = $urandom_range(0, shadow_count - 1);
      r = $urandom_range(l, shadow_count - 1);
    end else begin
      l = $urandom_range(0, MAX_ELEMENTS - 1);
      r = $urandom_range(0, MAX_ELEMENTS - 1);
    end
    return mk(CMD_QUERY, $urandom(), l, r);
  endfunction

  // directed table
  stim_row_t directed [] = '{
    mkq(0, 0, 0, ST_NOT_BUILT),
    mk(CMD_BUILD),
    mkq(0, 0, 0, ST_BAD_RANGE),
    mk(CMD_APPEND, 32'sh7fffffff),
    mkq(0, 0, 0, ST_NOT_BUILT),
    mk(CMD_APPEND, 32'sh80000000),
    mk(CMD_APPEND, 0),
    mk(CMD_APPEND, -1),
    mk(CMD_APPEND, 5),
    mk(CMD_BUILD),
    mkq(0, 4, 32'sh80000000, ST_OK),
    mkq(0, 0, 32'sh7fffffff, ST_OK),
    mkq(3, 2, 0, ST_BAD_RANGE),
    mkq(0, 5, 0, ST_BAD_RANGE),
    mk(CMD_QUERY, 0, 3, 4),
    mk(CMD_APPEND, 5),
    mk(CMD_BUILD),
    mk(CMD_QUERY, 0, 4, 5),
    mkq(1023, 1023, 0, ST_BAD_RANGE),
    mk(CMD_CLEAR),
    mkq(0, 0, 0, ST_NOT_BUILT),
    mk(CMD_BUILD),
    mkq(0, 0, 0, ST_BAD_RANGE)
  };

  initial begin
    int n;
    int nq;
    bit narrow;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_CLEAR;
    in_value = '0;
    in_left_index = '0;
    in_right_index = '0;
    shadow_count = 0;
    shadow_built = 0;
    burst_left = 0;
    sent = 0;
    hold_go = 0;
    stim_done = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_beat(directed[i]);
    in_valid <= 1'b0;
    wait (pending_mins.size() == 0);
    @(negedge clk);

    hold_go = 1;
    while (sent < ITEM_TOTAL) begin
      if ($urandom_range(0, 4) != 0) begin
        send_beat(mk(CMD_CLEAR));
        case ($urandom_range(0, 49))
          0: n = $urandom_range(60, 120);
          default: n = $urandom_range(1, 40);
        endcase
        narrow = $urandom_range(0, 2) == 0;
        for (int i = 0; i < n; i++) send_beat(mk(CMD_APPEND, rand_value(narrow)));
        if ($urandom_range(0, 9) != 0) send_beat(mk(CMD_BUILD));
        nq = $urandom_range(3, 10);
        for (int i = 0; i < nq; i++) begin
          if ($urandom_range(0, 19) == 0) send_beat(mk(CMD_APPEND, rand_value(narrow)));
          send_beat(rand_query());
        end
      end else begin
        stim_row_t row;
        row = mk(cmd_t'($urandom_range(0, 3)), rand_value(0), $urandom_range(0, 1023),
                 $urandom_range(0, 1023));
        send_beat(row);
      end
      if ($urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        wait (pending_mins.size() == 0);
        @(negedge clk);
      end
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    int phase;
    out_ready = 1'b0;
    phase = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_go && phase == 0) begin
        out_ready <= 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(negedge clk);
        phase = 1;
      end
      case (($urandom_range(0, 63) + phase) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 3) == 0;
        default: out_ready <= $urandom_range(0, 3) != 0;
      endcase
    end
  end

  always @(posedge clk) begin
    min_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_mins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: min %0d status %0d", out_min_value, out_status);
      end else begin
        want = pending_mins.pop_front();
        if (out_min_value !== want.value || out_status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected min %0d status %0d, got min %0d status %0d",
                     want.value, want.status, out_min_value, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    idle_cycles = 0;
    wait (stim_done);
    wait (pending_mins.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_mins.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (pending_mins.size() != 0)
        $display("%0d expected results never arrived", pending_mins.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/rmqt_pkg.sv
design/rmqt_ctrl.sv
design/rmqt_dp.sv
design/range_minimum_query_table.sv
tb/sv/range_minimum_query_table_tb.sv
